// ----- src/uer_pkg.sv -----
// shared types, constants and register codes for the echo ranger
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package uer_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS      = 4;
    localparam int DIST_W         = 16;
    localparam int DIVISOR_W      = 8;
    localparam int LIM_W          = 18;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int LOW_TICKS      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CM     = 3'd4;

    localparam logic [7:0]  TRIG_WIDTH_RST = 8'd10;
    localparam logic [15:0] TIMEOUT_RST    = 16'd35000;
    localparam logic [7:0]  US_PER_CM_RST  = 8'd58;
    localparam logic [9:0]  MIN_CM_RST     = 10'd2;
    localparam logic [9:0]  MAX_CM_RST     = 10'd400;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_DIV  = 2'd1,
        CS_OUT  = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic start_req;
        logic echo;
    } sample_t;

    typedef struct packed {
        logic              trig;
        logic              busy_res;
        logic              done_res;
        logic              in_range;
        logic              timed_out;
        logic [DIST_W-1:0] distance_q4;
    } report_t;

    typedef struct packed {
        logic step;
        logic div_start;
        logic div_finish;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic meas_end;
        logic div_done;
    } stat_t;

endpackage

// ----- src/uer_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_div #(
    parameter int DW = uer_pkg::COUNT_BITS_DEF + uer_pkg::FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DW-1:0]                  dividend,
    input  logic [uer_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           done,
    output logic [DW-1:0]                  quotient
);

    localparam int DVW  = uer_pkg::DIVISOR_W;
    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DVW-1:0]  rem_reg, rem_next;
    logic [DVW-1:0]  dsr_reg, dsr_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [DVW:0]    shifted;
    logic            fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        fits      = (shifted >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(DW);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVW'(shifted - {1'b0, dsr_reg}) : shifted[DVW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/uer_dp.sv -----
// datapath: config registers, phase and counters, limits, divider and result registers
// depends on uer_pkg and uer_div
`timescale 1ns / 1ps

module uer_dp #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  uer_pkg::sample_t                sample,
    input  uer_pkg::cmd_t                   cmd,
    output uer_pkg::stat_t                  stat,
    output uer_pkg::report_t                report
);

    localparam int CW    = COUNT_BITS;
    localparam int DW    = CW + uer_pkg::FRAC_BITS;
    localparam int QW    = (DW > uer_pkg::DIST_W) ? DW : uer_pkg::DIST_W;
    localparam int TCW   = (CW > 16) ? CW : 16;
    localparam int LW    = (CW > uer_pkg::LIM_W) ? CW : uer_pkg::LIM_W;
    localparam int DVW   = uer_pkg::DIVISOR_W;
    localparam int LIMW  = uer_pkg::LIM_W;
    localparam int DISTW = uer_pkg::DIST_W;

    logic [7:0]  trig_width_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  us_per_cm_reg;
    logic [9:0]  min_cm_reg;
    logic [9:0]  max_cm_reg;

    uer_pkg::phase_t  phase_reg, phase_next;
    logic [CW-1:0]    tick_count_reg, tick_count_next;
    logic [CW-1:0]    pulse_count_reg, pulse_count_next;
    logic             echo_prev_reg;
    logic [DISTW-1:0] latest_distance_reg;
    logic [LIMW-1:0]  lo_reg, hi_reg;
    uer_pkg::report_t pend_reg, pend_next;
    uer_pkg::report_t out_reg;

    logic [CW-1:0]    tick_inc, pulse_inc;
    logic [7:0]       tw_eff;
    logic [DVW-1:0]   div_eff;
    logic             tmo_hit;
    logic             trig, done, tmo, meas_end;
    logic             div_done;
    logic [DW-1:0]    quotient;
    logic [QW-1:0]    quo_ext;
    logic [DISTW-1:0] dist_sat;
    logic             inr;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_width_reg <= uer_pkg::TRIG_WIDTH_RST;
            timeout_reg    <= uer_pkg::TIMEOUT_RST;
            us_per_cm_reg  <= uer_pkg::US_PER_CM_RST;
            min_cm_reg     <= uer_pkg::MIN_CM_RST;
            max_cm_reg     <= uer_pkg::MAX_CM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uer_pkg::REG_TRIG_WIDTH: trig_width_reg <= cfg_data[7:0];
                uer_pkg::REG_TIMEOUT:    timeout_reg    <= cfg_data[15:0];
                uer_pkg::REG_US_PER_CM:  us_per_cm_reg  <= cfg_data[7:0];
                uer_pkg::REG_MIN_CM:     min_cm_reg     <= cfg_data[9:0];
                uer_pkg::REG_MAX_CM:     max_cm_reg     <= cfg_data[9:0];
                default:                 ;
            endcase
        end
    end

    assign tw_eff    = (trig_width_reg == '0) ? 8'd1 : trig_width_reg;
    assign div_eff   = (us_per_cm_reg == '0) ? DVW'(1) : us_per_cm_reg;
    assign tick_inc  = (tick_count_reg == {CW{1'b1}}) ? tick_count_reg
                                                      : tick_count_reg + CW'(1);
    assign pulse_inc = (pulse_count_reg == {CW{1'b1}}) ? pulse_count_reg
                                                       : pulse_count_reg + CW'(1);
    assign tmo_hit   = (TCW'(tick_inc) >= TCW'(timeout_reg));

    // one tick of the measurement sequence
    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        pulse_count_next = pulse_count_reg;
        trig             = 1'b0;
        done             = 1'b0;
        tmo              = 1'b0;
        meas_end         = 1'b0;
        unique case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (sample.start_req)
                begin
                    phase_next      = uer_pkg::PH_TRIG_LOW;
                    tick_count_next = CW'(1);
                end
            end
            uer_pkg::PH_TRIG_LOW:
            begin
                tick_count_next = tick_inc;
                if (tick_inc >= CW'(uer_pkg::LOW_TICKS))
                begin
                    phase_next      = uer_pkg::PH_TRIG_HIGH;
                    tick_count_next = '0;
                end
            end
            uer_pkg::PH_TRIG_HIGH:
            begin
                trig            = 1'b1;
                tick_count_next = tick_inc;
                if (tick_inc >= CW'(tw_eff))
                begin
                    phase_next      = uer_pkg::PH_WAIT_RISE;
                    tick_count_next = '0;
                end
            end
            uer_pkg::PH_WAIT_RISE:
            begin
                tick_count_next = tick_inc;
                if (sample.echo && !echo_prev_reg)
                begin
                    phase_next       = uer_pkg::PH_MEASURE;
                    pulse_count_next = '0;
                end
                else if (tmo_hit)
                begin
                    phase_next = uer_pkg::PH_IDLE;
                    done       = 1'b1;
                    tmo        = 1'b1;
                end
            end
            uer_pkg::PH_MEASURE:
            begin
                tick_count_next  = tick_inc;
                pulse_count_next = pulse_inc;
                if (!sample.echo)
                begin
                    phase_next = uer_pkg::PH_IDLE;
                    done       = 1'b1;
                    meas_end   = 1'b1;
                end
                else if (tmo_hit)
                begin
                    phase_next = uer_pkg::PH_IDLE;
                    done       = 1'b1;
                    tmo        = 1'b1;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= uer_pkg::PH_IDLE;
            tick_count_reg      <= '0;
            pulse_count_reg     <= '0;
            echo_prev_reg       <= 1'b0;
            latest_distance_reg <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                phase_reg       <= phase_next;
                tick_count_reg  <= tick_count_next;
                pulse_count_reg <= pulse_count_next;
                echo_prev_reg   <= sample.echo;
            end
            if (cmd.div_finish)
            begin
                latest_distance_reg <= dist_sat;
            end
        end
    end

    uer_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({pulse_inc, uer_pkg::FRAC_BITS'(0)}),
        .divisor  (div_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    assign quo_ext  = QW'(quotient);
    assign dist_sat = (quo_ext > QW'({DISTW{1'b1}})) ? {DISTW{1'b1}}
                                                     : quo_ext[DISTW-1:0];
    assign inr      = (LW'(pulse_count_reg) >= LW'(lo_reg))
                   && (LW'(pulse_count_reg) <= LW'(hi_reg));

    always_comb
    begin
        pend_next = pend_reg;
        if (cmd.step)
        begin
            pend_next.trig        = trig;
            pend_next.busy_res    = (phase_next != uer_pkg::PH_IDLE);
            pend_next.done_res    = done;
            pend_next.in_range    = 1'b0;
            pend_next.timed_out   = tmo;
            pend_next.distance_q4 = latest_distance_reg;
        end
        else if (cmd.div_finish)
        begin
            pend_next.in_range    = inr;
            pend_next.distance_q4 = dist_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (cmd.step)
        begin
            lo_reg <= LIMW'(min_cm_reg) * LIMW'(div_eff);
            hi_reg <= LIMW'(max_cm_reg) * LIMW'(div_eff);
        end
        if (cmd.load_out)
        begin
            out_reg <= pend_reg;
        end
    end

    assign stat.meas_end = meas_end;
    assign stat.div_done = div_done;
    assign report        = out_reg;

endmodule

// ----- src/uer_ctrl.sv -----
// controller: sequences sample transfer, divide and report transfer
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           sample_valid,
    output logic           sample_ready,
    output logic           report_valid,
    input  logic           report_ready,
    input  uer_pkg::stat_t stat,
    output uer_pkg::cmd_t  cmd
);

    uer_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uer_pkg::CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !report_ready;
        sample_ready   = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            uer_pkg::CS_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.step = 1'b1;
                    if (stat.meas_end)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = uer_pkg::CS_DIV;
                    end
                    else
                    begin
                        state_next = uer_pkg::CS_OUT;
                    end
                end
            end
            uer_pkg::CS_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_finish = 1'b1;
                    state_next     = uer_pkg::CS_OUT;
                end
            end
            uer_pkg::CS_OUT:
            begin
                if (!out_valid_reg || report_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = uer_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = uer_pkg::CS_IDLE;
            end
        endcase
    end

    assign report_valid = out_valid_reg;

endmodule

// ----- src/ultrasonic_echo_ranger.sv -----
// a sample transfer loads the pending report register, which moves to the output register
// once no earlier report is held; on the echo falling edge a bit-serial divide of the
// COUNT_BITS+4 bit dividend comes first. no further sample is taken until the report is
// loaded, and the report register lets the next sample in while a report waits
// reset: config registers to defaults, phase idle, counters, echo history and distance zero
// depends on uer_pkg, uer_ctrl, uer_dp
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  uer_pkg::sample_t                sample,
    output logic                            report_valid,
    input  logic                            report_ready,
    output uer_pkg::report_t                report
);

    uer_pkg::cmd_t  cmd;
    uer_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    uer_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    uer_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .stat      (stat),
        .report    (report)
    );

endmodule

// ----- tb/sv/tb.sv -----
// testbench for ultrasonic_echo_ranger: directed and random tick streams with a scoreboard
// that predicts every report and checks each report transfer; depends on uer_pkg and the block rtl
`timescale 1ns / 1ps

module tb;

    localparam int ROUNDS       = 8;
    localparam int ROUND_ITEMS  = 120;
    localparam int DRAIN_CYCLES = 30;
    localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    class echo_report_board;
        logic [7:0]       trig_width;
        logic [15:0]      timeout_ticks;
        logic [7:0]       us_per_cm;
        logic [9:0]       min_cm;
        logic [9:0]       max_cm;
        uer_pkg::phase_t  phase;
        logic [15:0]      tick_count;
        logic [15:0]      pulse_count;
        logic             echo_prev;
        logic [15:0]      latest_dist;
        uer_pkg::report_t due_reports[$];
        int               mismatches;
        int               reports_seen;
        int               ended;
        int               ended_timeout;
        int               ended_in_range;

        function new();
            trig_width     = uer_pkg::TRIG_WIDTH_RST;
            timeout_ticks  = uer_pkg::TIMEOUT_RST;
            us_per_cm      = uer_pkg::US_PER_CM_RST;
            min_cm         = uer_pkg::MIN_CM_RST;
            max_cm         = uer_pkg::MAX_CM_RST;
            phase          = uer_pkg::PH_IDLE;
            tick_count     = '0;
            pulse_count    = '0;
            echo_prev      = 1'b0;
            latest_dist    = '0;
            mismatches     = 0;
            reports_seen   = 0;
            ended          = 0;
            ended_timeout  = 0;
            ended_in_range = 0;
        endfunction

        function void write_reg(logic [uer_pkg::CFG_IDX_W-1:0] idx,
                                logic [uer_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                uer_pkg::REG_TRIG_WIDTH: trig_width    = data[7:0];
                uer_pkg::REG_TIMEOUT:    timeout_ticks = data;
                uer_pkg::REG_US_PER_CM:  us_per_cm     = data[7:0];
                uer_pkg::REG_MIN_CM:     min_cm        = data[9:0];
                uer_pkg::REG_MAX_CM:     max_cm        = data[9:0];
                default:                 ;
            endcase
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function void note_sample(uer_pkg::sample_t s);
            uer_pkg::report_t r;
            logic [7:0]       div;
            logic [7:0]       tw;
            int unsigned      w;
            int unsigned      d;
            int unsigned      lo;
            int unsigned      hi;
            r   = '0;
            div = (us_per_cm == 8'd0) ? 8'd1 : us_per_cm;
            tw  = (trig_width == 8'd0) ? 8'd1 : trig_width;
            case (phase)
                uer_pkg::PH_IDLE:
                begin
                    if (s.start_req)
                    begin
                        phase      = uer_pkg::PH_TRIG_LOW;
                        tick_count = 16'd1;
                    end
                end
                uer_pkg::PH_TRIG_LOW:
                begin
                    tick_count = bump(tick_count);
                    if (tick_count >= 16'(uer_pkg::LOW_TICKS))
                    begin
                        phase      = uer_pkg::PH_TRIG_HIGH;
                        tick_count = '0;
                    end
                end
                uer_pkg::PH_TRIG_HIGH:
                begin
                    r.trig     = 1'b1;
                    tick_count = bump(tick_count);
                    if (tick_count >= 16'(tw))
                    begin
                        phase      = uer_pkg::PH_WAIT_RISE;
                        tick_count = '0;
                    end
                end
                uer_pkg::PH_WAIT_RISE:
                begin
                    tick_count = bump(tick_count);
                    if (s.echo && !echo_prev)
                    begin
                        phase       = uer_pkg::PH_MEASURE;
                        pulse_count = '0;
                    end
                    if (phase == uer_pkg::PH_WAIT_RISE && tick_count >= timeout_ticks)
                    begin
                        phase       = uer_pkg::PH_IDLE;
                        r.done_res  = 1'b1;
                        r.timed_out = 1'b1;
                    end
                end
                default:
                begin
                    tick_count  = bump(tick_count);
                    pulse_count = bump(pulse_count);
                    if (!s.echo)
                    begin
                        w           = 32'(pulse_count);
                        d           = (w * 32'd16) / 32'(div);
                        latest_dist = (d > 32'hFFFF) ? 16'hFFFF : d[15:0];
                        lo          = 32'(min_cm) * 32'(div);
                        hi          = 32'(max_cm) * 32'(div);
                        r.in_range  = (w >= lo && w <= hi);
                        phase       = uer_pkg::PH_IDLE;
                        r.done_res  = 1'b1;
                    end
                    else if (tick_count >= timeout_ticks)
                    begin
                        phase       = uer_pkg::PH_IDLE;
                        r.done_res  = 1'b1;
                        r.timed_out = 1'b1;
                    end
                end
            endcase
            echo_prev     = s.echo;
            r.busy_res    = (phase != uer_pkg::PH_IDLE);
            r.distance_q4 = latest_dist;
            due_reports.push_back(r);
        endfunction

        function void check_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
            end
        endfunction

        function void check_report(uer_pkg::report_t got);
            uer_pkg::report_t want;
            if (due_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: report with nothing expected, expected none got %h", $time, got);
                return;
            end
            want = due_reports.pop_front();
            reports_seen++;
            if (want.done_res)
            begin
                ended++;
                if (want.timed_out)
                    ended_timeout++;
                if (want.in_range)
                    ended_in_range++;
            end
            check_field("trig", 16'(want.trig), 16'(got.trig));
            check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
            check_field("done_res", 16'(want.done_res), 16'(got.done_res));
            check_field("in_range", 16'(want.in_range), 16'(got.in_range));
            check_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
            check_field("distance_q4", want.distance_q4, got.distance_q4);
        endfunction
    endclass

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                           sample_valid = 1'b0;
    logic                           sample_ready;
    uer_pkg::sample_t               sample       = '0;
    logic                           report_valid;
    logic                           report_ready = 1'b0;
    uer_pkg::report_t               report;

    echo_report_board sb = new();
    int idle_pct     = 0;
    int stall_pct    = 0;
    int samples_sent = 0;
    int cfg_writes   = 0;

    ultrasonic_echo_ranger u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        report_ready <= (int'($urandom_range(99)) >= stall_pct);
    end

    // transfer monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (sample_valid && sample_ready)
                sb.note_sample(sample);
            if (report_valid && report_ready)
                sb.check_report(report);
        end
    end

    function automatic void set_idling(input int mode);
        case (mode)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 81;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 81;
            end
            default:
            begin
                idle_pct  = 14;
                stall_pct = 14;
            end
        endcase
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    task automatic send_sample(input logic start_bit, input logic echo_bit);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= uer_pkg::sample_t'{start_req: start_bit, echo: echo_bit};
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic wait_drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    // start tick, trigger ticks, optional echo already high, gap, pulse, falling tick
    task automatic run_measurement(input int gap, input int width, input int pre_high,
                                   input bit start_on_fall, input bit noisy_trig);
        int tw;
        int quiet;
        tw    = (sb.trig_width == 8'd0) ? 1 : int'(sb.trig_width);
        quiet = (pre_high > 0 && gap < 1) ? 1 : gap;
        send_sample(1'b1, noisy_trig ? rand_bit() : 1'b0);
        for (int i = 0; i < tw + 1; i++)
        begin
            if (i == tw)
                send_sample(1'b0, pre_high > 0);
            else if (noisy_trig)
                send_sample(rand_bit(), rand_bit());
            else
                send_sample(1'b0, 1'b0);
        end
        repeat (pre_high) send_sample(1'b0, 1'b1);
        repeat (quiet) send_sample(1'b0, 1'b0);
        repeat (width) send_sample(1'b0, 1'b1);
        send_sample(start_on_fall, 1'b0);
    endtask

    task automatic apply_random_config(input bit wide_divisor);
        logic [7:0]  tw;
        logic [7:0]  upc;
        logic [9:0]  mn;
        logic [9:0]  mx;
        logic [15:0] junk;
        int          tmo;
        junk = 16'($urandom);
        tw   = 8'($urandom_range(1, 6));
        upc  = wide_divisor ? 8'($urandom_range(200, 255)) : 8'($urandom_range(1, 5));
        mn   = wide_divisor ? 10'd0 : 10'($urandom_range(0, 4));
        mx   = wide_divisor ? 10'd1 : 10'($urandom_range(mn, 20));
        tmo  = int'(mx) * int'(upc) + int'($urandom_range(14, 44));
        write_reg(uer_pkg::REG_TRIG_WIDTH, {junk[15:8], tw});
        write_reg(uer_pkg::REG_TIMEOUT, tmo[15:0]);
        write_reg(uer_pkg::REG_US_PER_CM, {junk[7:0], upc});
        write_reg(uer_pkg::REG_MIN_CM, {junk[5:0], mn});
        write_reg(uer_pkg::REG_MAX_CM, {junk[11:6], mx});
    endtask

    task automatic random_measurement();
        int div;
        int lo;
        int hi;
        int width;
        div = (sb.us_per_cm == 8'd0) ? 1 : int'(sb.us_per_cm);
        lo  = int'(sb.min_cm) * div;
        hi  = int'(sb.max_cm) * div;
        if ($urandom_range(9) < 3)
        begin
            case ($urandom_range(3))
                0:       width = lo - 1;
                1:       width = lo;
                2:       width = hi;
                default: width = hi + 1;
            endcase
        end
        else
            width = int'($urandom_range(1, (hi + 6 > 300) ? 300 : hi + 6));
        if (width < 1)
            width = 1;
        run_measurement(int'($urandom_range(0, 8)), width,
                        ($urandom_range(9) == 0) ? int'($urandom_range(1, 3)) : 0,
                        $urandom_range(9) == 0, rand_bit());
        repeat ($urandom_range(0, 3)) send_sample(1'b0, rand_bit());
    endtask

    initial
    begin
        #(10_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int round_start;
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, echo and start noise during the trigger
        set_idling(0);
        run_measurement(2, 6, 0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        wait_drain();

        // zero trigger width and divisor, timeout on the first wait tick
        write_reg(uer_pkg::REG_TRIG_WIDTH, 16'hA500);
        write_reg(uer_pkg::REG_US_PER_CM, 16'h3C00);
        write_reg(uer_pkg::REG_MIN_CM, 16'hA800);
        write_reg(uer_pkg::REG_MAX_CM, 16'hFFFF);
        write_reg(uer_pkg::REG_TIMEOUT, 16'h0000);
        write_reg(REG_UNUSED, 16'h5A5A);
        run_measurement(1, 3, 0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0);
        wait_drain();

        // echo already high at wait start, start on the done tick, then measure timeout
        write_reg(uer_pkg::REG_TIMEOUT, 16'd12);
        run_measurement(2, 2, 2, 1'b1, 1'b0);
        run_measurement(1, 20, 0, 1'b0, 1'b0);
        wait_drain();

        // largest divisor and limits
        write_reg(uer_pkg::REG_US_PER_CM, 16'h00FF);
        write_reg(uer_pkg::REG_MIN_CM, 16'h03FF);
        write_reg(uer_pkg::REG_MAX_CM, 16'h03FF);
        write_reg(uer_pkg::REG_TIMEOUT, 16'd400);
        run_measurement(0, 1, 0, 1'b0, 1'b1);
        wait_drain();
        write_reg(uer_pkg::REG_MIN_CM, 16'd0);
        write_reg(uer_pkg::REG_MAX_CM, 16'd1);
        run_measurement(1, 200, 0, 1'b0, 1'b0);
        wait_drain();

        // widest trigger, long echo past the upper limit
        write_reg(uer_pkg::REG_TRIG_WIDTH, 16'h00FF);
        write_reg(uer_pkg::REG_TIMEOUT, 16'hFFFF);
        write_reg(uer_pkg::REG_US_PER_CM, 16'd1);
        write_reg(uer_pkg::REG_MIN_CM, 16'd0);
        write_reg(uer_pkg::REG_MAX_CM, 16'd0);
        run_measurement(3, 200, 0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0);

        for (int round = 0; round < ROUNDS; round++)
        begin
            wait_drain();
            set_idling(round % 4);
            apply_random_config(round == ROUNDS - 1);
            round_start = samples_sent;
            while (samples_sent - round_start < ROUND_ITEMS)
            begin
                pick = int'($urandom_range(99));
                if (pick < 4)
                    wait_drain();
                else if (pick < 76)
                    random_measurement();
                else if (pick < 90)
                    repeat ($urandom_range(1, 10)) send_sample(rand_bit(), rand_bit());
                else if ($urandom_range(1) == 0)
                    run_measurement(0, int'(sb.timeout_ticks) + 2, 0, 1'b0, 1'b1);
                else
                    run_measurement(int'(sb.timeout_ticks) + 2, 1, 0, 1'b0, 1'b1);
            end
        end
        wait_drain();

        $display("covered %0d samples and %0d reports over %0d register writes",
                 samples_sent, sb.reports_seen, cfg_writes);
        $display("measurements ended %0d, timed out %0d, in range %0d",
                 sb.ended, sb.ended_timeout, sb.ended_in_range);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- ultrasonic_echo_ranger.f -----
src/uer_pkg.sv
src/uer_div.sv
src/uer_dp.sv
src/uer_ctrl.sv
src/ultrasonic_echo_ranger.sv
tb/sv/tb.sv
